// File: hdl/psq_pkg.sv
// Shared types, codes and defaults of the packet slot queue.
package psq_pkg;

    // Default sizing of the queue
    localparam int SLOTS_DEF         = 16;
    localparam int PAYLOAD_BYTES_DEF = 1024;
    localparam int HEADER_BYTES_DEF  = 8;

    // Fixed widths of the word fields
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int LENGTH_W = 11;
    localparam int QUEUED_W = 5;

    // Operation code of an input word
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_OVERSIZE = 3'd3,
        ST_SHORT    = 3'd4
    } status_t;

    // Command classes handed from the front to the back
    typedef enum logic [1:0] {
        CMD_WRITE      = 2'd0,
        CMD_WRITE_LAST = 2'd1,
        CMD_READ       = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BYTE_W-1:0]  data;
    } cmd_t;

endpackage

// File: hdl/psq_front.sv
// Front end: accepts input words, classifies them and buffers them as commands.
module psq_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [psq_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        in_last,
    output logic                        cmd_valid,
    output psq_pkg::cmd_t               cmd,
    input  logic                        cmd_take
);
    import psq_pkg::*;

    cmd_t        q_reg [0:1];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    cmd_t        in_cmd;

    // Classify the incoming word
    always_comb
    begin
        in_cmd.data = in_byte;
        if (opcode == OP_READ)
            in_cmd.kind = CMD_READ;
        else if (in_last)
            in_cmd.kind = CMD_WRITE_LAST;
        else
            in_cmd.kind = CMD_WRITE;
    end

    // Two-entry command queue control
    assign in_stall  = (fill_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_take ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(cmd_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage, payload only
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

// File: hdl/psq_back.sv
// Back end: slot memories, ring pointers, packet checks and the result register.
module psq_back #(
    parameter int SLOTS         = psq_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BYTES = psq_pkg::PAYLOAD_BYTES_DEF,
    parameter int HEADER_BYTES  = psq_pkg::HEADER_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  psq_pkg::cmd_t                  cmd,
    output logic                           cmd_take,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [psq_pkg::BYTE_W-1:0]     out_byte,
    output logic                           out_last,
    output logic [psq_pkg::STATUS_W-1:0]   status,
    output logic [psq_pkg::LENGTH_W-1:0]   packet_length,
    output logic [psq_pkg::QUEUED_W-1:0]   queued_packets
);
    import psq_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int IDX_W  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int LEN_W  = $clog2(PAYLOAD_BYTES + 1);
    localparam int CAP    = HEADER_BYTES + PAYLOAD_BYTES + 1;
    localparam int IC_W   = $clog2(CAP + 1);
    localparam int ADDR_W = SLOT_W + IDX_W;
    localparam int DEPTH  = SLOTS * (2 ** IDX_W);

    // Memories
    logic [BYTE_W-1:0] slot_bytes_mem [0:DEPTH-1];
    logic [LEN_W-1:0]  slot_len_mem   [0:SLOTS-1];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [LEN_W-1:0]  head_len_reg;

    // Queue state
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IC_W-1:0]   ic_reg, ic_next;
    logic [IDX_W-1:0]  ro_reg, ro_next;
    logic              full_seen_reg, full_seen_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic              use_byte_reg;
    logic              last_reg;
    status_t           status_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic [QUEUED_W-1:0] queued_reg;

    // Per-command decode
    logic              is_read, is_write, is_last;
    logic              full, empty, fs_w, ic_inc, in_payload;
    logic              byte_we, byte_re, commit, rd_ok, rd_last, has_byte;
    logic [IC_W-1:0]   ic_new;
    logic [LEN_W-1:0]  commit_len;
    logic [LEN_W:0]    ro_plus1;
    logic [ADDR_W-1:0] byte_waddr, byte_raddr;
    status_t           res_status;
    logic [LEN_W-1:0]  res_len;

    assign cmd_take = cmd_valid && (!out_valid_reg || !out_stall);
    assign is_read  = cmd_take && (cmd.kind == CMD_READ);
    assign is_write = cmd_take && (cmd.kind != CMD_READ);
    assign is_last  = (cmd.kind == CMD_WRITE_LAST);

    assign full  = (count_reg == CNT_W'(SLOTS));
    assign empty = (count_reg == '0);

    // Write path: header skip, payload store, saturating count
    assign fs_w       = full_seen_reg || full;
    assign ic_inc     = (ic_reg < IC_W'(CAP));
    assign ic_new     = ic_inc ? ic_reg + 1'b1 : ic_reg;
    assign in_payload = (ic_reg >= IC_W'(HEADER_BYTES))
                     && (ic_reg < IC_W'(HEADER_BYTES + PAYLOAD_BYTES));
    assign byte_we    = is_write && ic_inc && !full && in_payload;
    assign byte_waddr = {tail_reg, IDX_W'(ic_reg - IC_W'(HEADER_BYTES))};
    assign commit_len = LEN_W'(ic_new - IC_W'(HEADER_BYTES));

    // End-of-packet checks, full before short before oversize
    always_comb
    begin
        res_status = ST_OK;
        commit     = 1'b0;
        if (is_write && is_last)
        begin
            if (fs_w)
                res_status = ST_FULL;
            else if (ic_new < IC_W'(HEADER_BYTES))
                res_status = ST_SHORT;
            else if (ic_new > IC_W'(HEADER_BYTES + PAYLOAD_BYTES))
                res_status = ST_OVERSIZE;
            else
                commit = 1'b1;
        end
        else if (is_read && empty)
            res_status = ST_EMPTY;
    end

    // Read path: next byte of the head slot
    assign rd_ok      = is_read && !empty;
    assign has_byte   = (LEN_W'(ro_reg) < head_len_reg);
    assign ro_plus1   = {1'b0, LEN_W'(ro_reg)} + 1'b1;
    assign rd_last    = (ro_plus1 >= {1'b0, head_len_reg});
    assign byte_re    = rd_ok && has_byte;
    assign byte_raddr = {head_reg, ro_reg};

    // Next state of the ring
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        ic_next        = ic_reg;
        ro_next        = ro_reg;
        full_seen_next = full_seen_reg;
        if (is_write)
        begin
            ic_next        = ic_new;
            full_seen_next = fs_w;
            if (is_last)
            begin
                ic_next        = '0;
                full_seen_next = 1'b0;
            end
            if (commit)
            begin
                tail_next  = (tail_reg == SLOT_W'(SLOTS - 1)) ? '0 : tail_reg + 1'b1;
                count_next = count_reg + 1'b1;
            end
        end
        else if (rd_ok)
        begin
            if (rd_last)
            begin
                ro_next    = '0;
                head_next  = (head_reg == SLOT_W'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
                count_next = count_reg - 1'b1;
            end
            else
                ro_next = ro_reg + 1'b1;
        end
    end

    assign res_len        = commit ? commit_len : (rd_ok ? head_len_reg : '0);
    assign out_valid_next = cmd_take ? 1'b1 : (out_valid_reg && out_stall);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            ic_reg        <= '0;
            ro_reg        <= '0;
            full_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            ic_reg        <= ic_next;
            ro_reg        <= ro_next;
            full_seen_reg <= full_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded with each command
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            use_byte_reg <= byte_re;
            last_reg     <= rd_ok && rd_last;
            status_reg   <= res_status;
            length_reg   <= LENGTH_W'(res_len);
            queued_reg   <= QUEUED_W'(count_next);
        end
    end

    // Payload byte memory, one access per cycle
    always_ff @(posedge clk)
    begin
        if (byte_we)
            slot_bytes_mem[byte_waddr] <= cmd.data;
        if (byte_re)
            rd_data_reg <= slot_bytes_mem[byte_raddr];
    end

    // Length memory; the head slot's length is read ahead every cycle
    always_ff @(posedge clk)
    begin
        if (commit)
            slot_len_mem[tail_reg] <= commit_len;
        if (commit && (tail_reg == head_next))
            head_len_reg <= commit_len;
        else
            head_len_reg <= slot_len_mem[head_next];
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = use_byte_reg ? rd_data_reg : '0;
    assign out_last       = last_reg;
    assign status         = status_reg;
    assign packet_length  = length_reg;
    assign queued_packets = queued_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("packet count above slot count");

    a_ring_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

    a_offset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ro_reg != '0) |-> (count_reg != '0))
        else $error("read offset set with no packet queued");

    a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_ok && rd_last) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("final byte read did not free a slot");
`endif

endmodule

// File: hdl/packet_slot_queue.sv
// Top level of the packet slot queue: front end, command queue and back end.
//
//  channel | words            | handshake           | fields
//  --------+------------------+---------------------+-------------------------------------
//  in      | write/read word  | in_valid, in_stall  | opcode, in_byte, in_last
//  out     | result word      | out_valid, out_stall| out_byte, out_last, status,
//          |                  |                     | packet_length, queued_packets
//
//  One word per cycle sustained while out_stall is low; every word gives exactly one result word.
//  A word is held in the two-entry command queue and then in the back end's result register;
//  the back end's single-port byte memory serves one write or one read a cycle.
//  rst_n clears pointers and counts at once; no clearing pass is needed.
//  in_stall rises only when the command queue is full; out_stall holds the
//  result register, and the queue then fills behind it.
module packet_slot_queue #(
    parameter int SLOTS         = psq_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BYTES = psq_pkg::PAYLOAD_BYTES_DEF,
    parameter int HEADER_BYTES  = psq_pkg::HEADER_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           opcode,
    input  logic [psq_pkg::BYTE_W-1:0]     in_byte,
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [psq_pkg::BYTE_W-1:0]     out_byte,
    output logic                           out_last,
    output logic [psq_pkg::STATUS_W-1:0]   status,
    output logic [psq_pkg::LENGTH_W-1:0]   packet_length,
    output logic [psq_pkg::QUEUED_W-1:0]   queued_packets
);
    import psq_pkg::*;

    logic  cmd_valid;
    logic  cmd_take;
    cmd_t  cmd;

    // Accept and classify
    psq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // Execute against the slot memory
    psq_back #(
        .SLOTS         (SLOTS),
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .out_last       (out_last),
        .status         (status),
        .packet_length  (packet_length),
        .queued_packets (queued_packets)
    );

endmodule

// File: sim/psq_checker.sv
// Checker for the packet slot queue: predicts every result word and compares it.
`timescale 1ns / 1ps

module psq_checker #(
    parameter int SLOTS         = psq_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BYTES = psq_pkg::PAYLOAD_BYTES_DEF,
    parameter int HEADER_BYTES  = psq_pkg::HEADER_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           opcode,
    input  logic [psq_pkg::BYTE_W-1:0]     in_byte,
    input  logic                           in_last,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [psq_pkg::BYTE_W-1:0]     out_byte,
    input  logic                           out_last,
    input  logic [psq_pkg::STATUS_W-1:0]   status,
    input  logic [psq_pkg::LENGTH_W-1:0]   packet_length,
    input  logic [psq_pkg::QUEUED_W-1:0]   queued_packets,
    output int                             mismatches,
    output int                             pending,
    output int                             n_commit,
    output int                             n_drop,
    output int                             n_full_drop,
    output int                             n_empty,
    output int                             n_freed
);

    localparam int COUNT_CAP  = HEADER_BYTES + PAYLOAD_BYTES + 1;
    localparam int MAX_REPORT = 40;

    typedef struct packed {
        logic [psq_pkg::BYTE_W-1:0]   data;
        logic                         last;
        psq_pkg::status_t             stat;
        logic [psq_pkg::LENGTH_W-1:0] length;
        logic [psq_pkg::QUEUED_W-1:0] queued;
    } result_word_t;

    // Shadow copy of the queue state
    logic [psq_pkg::BYTE_W-1:0] payload_mem [0:SLOTS*PAYLOAD_BYTES-1];
    int  slot_len [0:SLOTS-1];
    int  head_idx;
    int  tail_idx;
    int  stored_pkts;
    int  rx_count;
    int  rd_pos;
    bit  saw_full;

    result_word_t awaited_words [$];

    // Advance the shadow queue by one input word and give the result word it causes
    function automatic result_word_t slot_queue_step(input logic op,
                                                     input logic [psq_pkg::BYTE_W-1:0] b,
                                                     input logic lst);
        result_word_t r;
        bit full;
        int pos;
        r = '0;
        r.stat = psq_pkg::ST_OK;
        if (op == psq_pkg::OP_WRITE)
        begin
            full = (stored_pkts >= SLOTS);
            if (full)
                saw_full = 1'b1;
            // header bytes are counted but not kept; count saturates past the cap
            if (rx_count < COUNT_CAP)
            begin
                pos = rx_count;
                rx_count++;
                if (!full && pos >= HEADER_BYTES && pos - HEADER_BYTES < PAYLOAD_BYTES)
                    payload_mem[tail_idx*PAYLOAD_BYTES + pos - HEADER_BYTES] = b;
            end
            if (lst)
            begin
                if (saw_full)
                    r.stat = psq_pkg::ST_FULL;
                else if (rx_count < HEADER_BYTES)
                    r.stat = psq_pkg::ST_SHORT;
                else if (rx_count - HEADER_BYTES > PAYLOAD_BYTES)
                    r.stat = psq_pkg::ST_OVERSIZE;
                else
                begin
                    r.length = psq_pkg::LENGTH_W'(rx_count - HEADER_BYTES);
                    slot_len[tail_idx] = rx_count - HEADER_BYTES;
                    tail_idx = (tail_idx + 1) % SLOTS;
                    stored_pkts++;
                end
                rx_count = 0;
                saw_full = 1'b0;
            end
        end
        else if (stored_pkts == 0)
            r.stat = psq_pkg::ST_EMPTY;
        else
        begin
            r.length = psq_pkg::LENGTH_W'(slot_len[head_idx]);
            if (rd_pos < slot_len[head_idx])
                r.data = payload_mem[head_idx*PAYLOAD_BYTES + rd_pos];
            // a zero-length packet also ends on its first read
            if (rd_pos + 1 >= slot_len[head_idx])
            begin
                r.last = 1'b1;
                rd_pos = 0;
                head_idx = (head_idx + 1) % SLOTS;
                stored_pkts--;
            end
            else
                rd_pos++;
        end
        r.queued = psq_pkg::QUEUED_W'(stored_pkts);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORT)
            $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Watch both channels; results are checked before new words are predicted
    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_len[i] = 0;
            head_idx    = 0;
            tail_idx    = 0;
            stored_pkts = 0;
            rx_count    = 0;
            rd_pos      = 0;
            saw_full    = 1'b0;
            awaited_words.delete();
            mismatches  = 0;
            pending     = 0;
            n_commit    = 0;
            n_drop      = 0;
            n_full_drop = 0;
            n_empty     = 0;
            n_freed     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_words.size() == 0)
                    report_mismatch("result word with none awaited", int'(status), -1);
                else
                begin
                    want = awaited_words[0];
                    awaited_words.delete(0);
                    if (out_byte !== want.data)
                        report_mismatch("out_byte", int'(out_byte), int'(want.data));
                    if (out_last !== want.last)
                        report_mismatch("out_last", int'(out_last), int'(want.last));
                    if (status !== want.stat)
                        report_mismatch("status", int'(status), int'(want.stat));
                    if (packet_length !== want.length)
                        report_mismatch("packet_length", int'(packet_length),
                                        int'(want.length));
                    if (queued_packets !== want.queued)
                        report_mismatch("queued_packets", int'(queued_packets),
                                        int'(want.queued));
                    // tallies for the closing summary
                    case (want.stat)
                        psq_pkg::ST_EMPTY:    n_empty++;
                        psq_pkg::ST_FULL:
                        begin
                            n_drop++;
                            n_full_drop++;
                        end
                        psq_pkg::ST_OVERSIZE: n_drop++;
                        psq_pkg::ST_SHORT:    n_drop++;
                        default:
                        begin
                            if (want.last)
                                n_freed++;
                        end
                    endcase
                end
            end
            if (in_valid && !in_stall)
            begin
                want = slot_queue_step(opcode, in_byte, in_last);
                if (opcode == psq_pkg::OP_WRITE && in_last && want.stat == psq_pkg::ST_OK)
                    n_commit++;
                awaited_words = {awaited_words, want};
            end
            pending = awaited_words.size();
        end
    end

endmodule

// File: sim/tb_top.sv
// Testbench top for the packet slot queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int LONG_HOLD    = 64;
    localparam int RANDOM_WORDS = 150;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic                           opcode;
    logic [psq_pkg::BYTE_W-1:0]     in_byte;
    logic                           in_last;
    logic                           out_valid;
    logic                           out_stall;
    logic [psq_pkg::BYTE_W-1:0]     out_byte;
    logic                           out_last;
    logic [psq_pkg::STATUS_W-1:0]   status;
    logic [psq_pkg::LENGTH_W-1:0]   packet_length;
    logic [psq_pkg::QUEUED_W-1:0]   queued_packets;

    int mismatches;
    int pending;
    int n_commit;
    int n_drop;
    int n_full_drop;
    int n_empty;
    int n_freed;

    int words_sent;
    bit tx_idle;
    bit rx_idle;
    bit long_hold;

    packet_slot_queue i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .in_byte        (in_byte),
        .in_last        (in_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .out_last       (out_last),
        .status         (status),
        .packet_length  (packet_length),
        .queued_packets (queued_packets)
    );

    psq_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .in_byte        (in_byte),
        .in_last        (in_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .out_last       (out_last),
        .status         (status),
        .packet_length  (packet_length),
        .queued_packets (queued_packets),
        .mismatches     (mismatches),
        .pending        (pending),
        .n_commit       (n_commit),
        .n_drop         (n_drop),
        .n_full_drop    (n_full_drop),
        .n_empty        (n_empty),
        .n_freed        (n_freed)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #20_000_000;
        $display("Timed out with %0d result words outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one word, after a random gap when tx_idle is set; called and left at a falling edge
    task automatic send_word(input logic op, input logic [psq_pkg::BYTE_W-1:0] b,
                             input logic lst);
        int gap;
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        in_byte  <= b;
        in_last  <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // Whole packet of random bytes, header included
    task automatic send_packet(input int total);
        for (int i = 0; i < total; i++)
            send_word(psq_pkg::OP_WRITE, 8'($urandom_range(0, 255)), i == total - 1);
    endtask

    // Reads carry random don't-care byte and last fields
    task automatic read_words(input int n);
        repeat (n)
            send_word(psq_pkg::OP_READ, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic send_noise(input int n);
        repeat (n)
            send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
    endtask

    // Sender pauses until every awaited result word is back
    task automatic drain_queue();
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // Receiver: random stall per word when rx_idle is set, plus a long hold-off on request
    initial
    begin : receiver
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            gap = rx_idle ? $urandom_range(0, 13) : 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int target;
        int guard;
        int pick;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        opcode   = psq_pkg::OP_WRITE;
        in_byte  = '0;
        in_last  = 1'b0;
        tx_idle  = 1'b1;
        rx_idle  = 1'b1;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty read, short packet, zero-length packet, byte extremes
        send_word(psq_pkg::OP_READ, 8'h00, 1'b0);
        send_word(psq_pkg::OP_WRITE, 8'hFF, 1'b1);
        send_packet(psq_pkg::HEADER_BYTES_DEF);
        send_word(psq_pkg::OP_READ, 8'hFF, 1'b1);
        repeat (psq_pkg::HEADER_BYTES_DEF)
            send_word(psq_pkg::OP_WRITE, 8'($urandom_range(0, 255)), 1'b0);
        send_word(psq_pkg::OP_WRITE, 8'h00, 1'b0);
        send_word(psq_pkg::OP_WRITE, 8'hFF, 1'b0);
        send_word(psq_pkg::OP_WRITE, 8'h5A, 1'b1);
        read_words(4);
        drain_queue();

        // Fill every slot, then drop on full, including a packet that sees a slot freed
        repeat (psq_pkg::SLOTS_DEF)
            send_packet(psq_pkg::HEADER_BYTES_DEF + $urandom_range(0, 4));
        send_packet(psq_pkg::HEADER_BYTES_DEF + $urandom_range(0, 4));
        repeat (3)
            send_word(psq_pkg::OP_WRITE, 8'($urandom_range(0, 255)), 1'b0);
        read_words(5);
        send_packet(10);
        read_words(70);
        drain_queue();

        // Size extreme: oversize packet whose byte count saturates
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_packet(psq_pkg::HEADER_BYTES_DEF + psq_pkg::PAYLOAD_BYTES_DEF + 2);
        drain_queue();

        // Back-pressure: receiver holds off while the sender keeps going
        long_hold = 1'b1;
        repeat (3)
            send_packet(psq_pkg::HEADER_BYTES_DEF + $urandom_range(0, 10));
        read_words(40);
        drain_queue();

        // Random mix of packets, read runs, short packets, noise, drains and long holds
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            tx_idle = ($urandom_range(0, 4) != 0);
            rx_idle = ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_packet(psq_pkg::HEADER_BYTES_DEF + $urandom_range(0, 24));
            else if (pick < 50)
                repeat ($urandom_range(2, 6))
                    send_packet(psq_pkg::HEADER_BYTES_DEF + $urandom_range(0, 6));
            else if (pick < 80)
                read_words($urandom_range(1, 30));
            else if (pick < 88)
                send_packet($urandom_range(1, psq_pkg::HEADER_BYTES_DEF - 1));
            else if (pick < 94)
                send_noise($urandom_range(1, 5));
            else if (pick < 97)
                drain_queue();
            else
            begin
                long_hold = 1'b1;
                tx_idle = 1'b0;
                repeat (2)
                    send_packet(psq_pkg::HEADER_BYTES_DEF + $urandom_range(0, 12));
            end
        end

        // Wind down: wait, with a guard, for the last result words, then give the verdict
        in_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d words: %0d packets committed, %0d read out, %0d empty reads",
                 words_sent, n_commit, n_freed, n_empty);
        $display("Dropped %0d packets (%0d on a full queue); %0d field mismatches",
                 n_drop, n_full_drop, mismatches);
        if (pending != 0)
            $display("%0d result words never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
hdl/psq_pkg.sv
hdl/psq_front.sv
hdl/psq_back.sv
hdl/packet_slot_queue.sv
sim/psq_checker.sv
sim/tb_top.sv
